@@ rtl/dq_pkg.sv @@
// shared opcodes and the fixed data port width for the double-ended queue
`default_nettype none

package dq_pkg;

  // width of the data ports, independent of the stored word width
  localparam int unsigned PORT_W = 32;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

endpackage

`default_nettype wire

@@ rtl/dq_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/dq_ctrl.sv @@
// pointer and count sequencer for the double-ended queue
`default_nettype none

module dq_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned IDX_W     = $clog2(DEPTH),
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [2:0]                in_opcode,
  input  wire logic [dq_pkg::PORT_W-1:0] in_data_value,
  output logic                           busy,
  output logic                           res_valid,
  output logic                           res_dropped,
  output logic [CNT_W-1:0]               res_count,
  output logic                           wr_en,
  output logic [IDX_W-1:0]               wr_addr,
  output logic [DATA_WIDTH-1:0]          wr_data,
  output logic [IDX_W-1:0]               front_addr,
  output logic [IDX_W-1:0]               back_addr
);

  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             valid_r, valid_nxt;
  logic             drop_r, drop_nxt;

  logic             accept;
  logic             full;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] back_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] prev_idx;
  logic [IDX_W-1:0] next_idx;
  logic [63:0]      word_ext;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign full   = (count_r == CNT_W'(DEPTH));

  // slot after the back entry, and the back entry itself
  assign tail_sum = SUM_W'(front_r) + SUM_W'(count_r);
  assign back_sum = tail_sum - SUM_W'(1);
  assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                : IDX_W'(tail_sum);
  assign prev_idx = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  assign next_idx = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + IDX_W'(1);

  assign front_addr = front_r;
  always_comb begin
    if (count_r == '0) begin
      back_addr = front_r;
    end else if (back_sum >= SUM_W'(DEPTH)) begin
      back_addr = IDX_W'(back_sum - SUM_W'(DEPTH));
    end else begin
      back_addr = IDX_W'(back_sum);
    end
  end

  assign word_ext = 64'(in_data_value);
  assign wr_data  = word_ext[DATA_WIDTH-1:0];

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    valid_nxt = 1'b0;
    drop_nxt  = drop_r;
    wr_en     = 1'b0;
    wr_addr   = tail_idx;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
          drop_nxt  = 1'b0;
          case (in_opcode)
            dq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            dq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = prev_idx;
                front_nxt = prev_idx;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            dq_pkg::OP_POP_FRONT: begin
              if (count_r != '0) begin
                front_nxt = next_idx;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            dq_pkg::OP_POP_BACK: begin
              if (count_r != '0) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            dq_pkg::OP_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
        valid_nxt = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign res_valid   = valid_r;
  assign res_dropped = drop_r;
  assign res_count   = count_r;

endmodule

`default_nettype wire

@@ rtl/double_ended_queue_top.sv @@
// top level of the double-ended queue held in ring storage
`default_nettype none

// usage
//   request channel: start with in_opcode and in_data_value; a request is
//   taken at a clock edge with start high and busy low
//   opcodes: none, push back, push front, pop front, pop back, clear
//   result channel: out_valid is high for exactly one cycle per request,
//   carrying front and back words, entry count, empty flag and a flag for
//   a push refused because the queue was full
// sequencing
//   the store is written at the edge that takes a request; both ends are
//   read from the ring storage in the read state, and the result shows
//   once that read data is registered; busy is high in the read state,
//   so the next request may be taken in the result cycle
// reset
//   synchronous active-low rst_n empties the queue and puts the front
//   pointer at slot 0; the storage itself is never cleared, since only
//   held entries are read
// the receiver cannot stall: a result not taken in its cycle is gone
module double_ended_queue_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_opcode,
  input  wire logic [dq_pkg::PORT_W-1:0]     in_data_value,
  output logic                               out_valid,
  output logic [dq_pkg::PORT_W-1:0]          out_front_value,
  output logic [dq_pkg::PORT_W-1:0]          out_back_value,
  output logic [$clog2(DEPTH + 1)-1:0]       out_entry_count,
  output logic                               out_is_empty,
  output logic                               out_push_dropped
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]      front_addr;
  logic [IDX_W-1:0]      back_addr;
  logic [DATA_WIDTH-1:0] front_rdata;
  logic [DATA_WIDTH-1:0] back_rdata;
  logic [CNT_W-1:0]      res_count;
  logic [63:0]           front_ext;
  logic [63:0]           back_ext;

  // pointers, count and request sequencing
  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_opcode     (in_opcode),
    .in_data_value (in_data_value),
    .busy          (busy),
    .res_valid     (out_valid),
    .res_dropped   (out_push_dropped),
    .res_count     (res_count),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .front_addr    (front_addr),
    .back_addr     (back_addr)
  );

  // two copies of the ring, written together, so both ends read at once
  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_front (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (front_addr),
    .rdata (front_rdata)
  );

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_back (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (back_addr),
    .rdata (back_rdata)
  );

  // stored words fit to the port width: zero-extended or low bits kept
  assign front_ext = 64'(front_rdata);
  assign back_ext  = 64'(back_rdata);

  // an empty queue reports zero at both ends
  assign out_is_empty    = (res_count == '0);
  assign out_entry_count = res_count;
  assign out_front_value = out_is_empty ? '0 : front_ext[dq_pkg::PORT_W-1:0];
  assign out_back_value  = out_is_empty ? '0 : back_ext[dq_pkg::PORT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/dq_checker.sv @@
// port-level checks for the double-ended queue, bound to the top level
`default_nettype none

module dq_checker #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [dq_pkg::PORT_W-1:0] out_front_value,
  input wire logic [dq_pkg::PORT_W-1:0] out_back_value,
  input wire logic [CNT_W-1:0]          out_entry_count,
  input wire logic                      out_is_empty,
  input wire logic                      out_push_dropped
);

  // a taken request raises busy, which blocks the next one
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a request");

  // every taken request is followed by its out_valid strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("result missing two cycles after a request");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_front_value == '0) && (out_back_value == '0))
    else $error("empty queue reports nonzero words");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_push_dropped |-> (out_entry_count == CNT_W'(DEPTH)))
    else $error("push refused while queue not full");

endmodule

bind double_ended_queue_top dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_front_value  (out_front_value),
  .out_back_value   (out_back_value),
  .out_entry_count  (out_entry_count),
  .out_is_empty     (out_is_empty),
  .out_push_dropped (out_push_dropped)
);

`default_nettype wire

@@ tb/double_ended_queue_top_tb.sv @@
// self-checking testbench for the double-ended queue top level
`timescale 1ns / 100ps

module double_ended_queue_top_tb;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  // watchdog limit, well above the length of a correct run
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_COUNT = 1920;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 8;

  // one pending request plus the idle chance applied before it goes out
  typedef struct {
    logic [2:0]                op;
    logic [dq_pkg::PORT_W-1:0] data;
    int unsigned               gap_pct;
  } dq_request_t;

  // status the block reports after each request
  typedef struct {
    logic [dq_pkg::PORT_W-1:0] front;
    logic [dq_pkg::PORT_W-1:0] back;
    logic [CNT_W-1:0]          count;
    logic                      empty;
    logic                      dropped;
  } dq_status_t;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         start         = 1'b0;
  logic [2:0]                   in_opcode     = '0;
  logic [dq_pkg::PORT_W-1:0]    in_data_value = '0;
  logic                         busy;
  logic                         out_valid;
  logic [dq_pkg::PORT_W-1:0]    out_front_value;
  logic [dq_pkg::PORT_W-1:0]    out_back_value;
  logic [CNT_W-1:0]             out_entry_count;
  logic                         out_is_empty;
  logic                         out_push_dropped;

  dq_request_t pending_requests[$];
  dq_status_t  predicted_status[$];

  // shadow copy of the deque contents
  logic [DATA_WIDTH-1:0] shadow_ring[DEPTH];
  logic [3:0]            shadow_front = '0;
  logic [CNT_W-1:0]      shadow_count = '0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned taken_count    = 0;
  int unsigned checked_count  = 0;
  int unsigned dropped_seen   = 0;
  int unsigned full_seen      = 0;
  int unsigned op_seen[8];

  double_ended_queue_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_data_value    (in_data_value),
    .out_valid        (out_valid),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_push_dropped (out_push_dropped)
  );

  always #5 clk = ~clk;

  // apply one taken request to the shadow deque and queue the status it implies
  function automatic void apply_deque_op(logic [2:0] op,
                                         logic [dq_pkg::PORT_W-1:0] data);
    dq_status_t st;
    logic       dropped;
    dropped = 1'b0;
    case (op)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (shadow_count >= CNT_W'(DEPTH)) begin
          // full: word is refused and nothing moves
          dropped = 1'b1;
        end else if (op == dq_pkg::OP_PUSH_BACK) begin
          shadow_ring[4'(shadow_front + shadow_count)] = data[DATA_WIDTH-1:0];
          shadow_count = shadow_count + 1'b1;
        end else begin
          // front steps back one slot, wrapping below slot 0
          shadow_front = shadow_front - 1'b1;
          shadow_ring[shadow_front] = data[DATA_WIDTH-1:0];
          shadow_count = shadow_count + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (shadow_count != 0) begin
          shadow_front = shadow_front + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (shadow_count != 0) shadow_count = shadow_count - 1'b1;
      end
      dq_pkg::OP_CLEAR: begin
        shadow_count = '0;
        shadow_front = '0;
      end
      default: begin
        // query, and the two unused codes act the same way
      end
    endcase
    if (shadow_count == 0) begin
      st.front = '0;
      st.back  = '0;
    end else begin
      st.front = dq_pkg::PORT_W'(shadow_ring[shadow_front]);
      st.back  = dq_pkg::PORT_W'(shadow_ring[4'(shadow_front + shadow_count - 1'b1)]);
    end
    st.count   = shadow_count;
    st.empty   = (shadow_count == 0);
    st.dropped = dropped;
    predicted_status.insert(predicted_status.size(), st);
  endfunction

  function automatic logic [dq_pkg::PORT_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return dq_pkg::PORT_W'($urandom);
    endcase
  endfunction

  task automatic add_request(logic [2:0] op, logic [dq_pkg::PORT_W-1:0] data,
                             int unsigned gap);
    dq_request_t r;
    r.op      = op;
    r.data    = data;
    r.gap_pct = gap;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  // driver: presents the next request once the current one is taken,
  // with a random idle chance per cycle set by the request's phase
  always @(posedge clk) begin : driver
    logic        taken;
    dq_request_t nxt;
    taken = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        apply_deque_op(in_opcode, in_data_value);
        taken_count++;
      end
      if (taken || !start) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99) >= pending_requests[0].gap_pct) begin
          nxt = pending_requests[0];
          pending_requests.delete(0);
          start         <= 1'b1;
          in_opcode     <= nxt.op;
          in_data_value <= nxt.data;
        end else begin
          // idle cycle: garbage on the payload must be ignored
          start         <= 1'b0;
          in_opcode     <= 3'($urandom);
          in_data_value <= dq_pkg::PORT_W'($urandom);
        end
      end
    end
  end

  // monitor: every strobed result is matched against the oldest prediction
  always @(posedge clk) begin : monitor
    dq_status_t exp_st;
    if (rst_n && out_valid) begin
      if (predicted_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: front %h back %h count %0d empty %b drop %b",
                   $realtime, out_front_value, out_back_value, out_entry_count,
                   out_is_empty, out_push_dropped);
      end else begin
        exp_st = predicted_status[0];
        predicted_status.delete(0);
        checked_count++;
        if (out_push_dropped) dropped_seen++;
        if (out_entry_count == CNT_W'(DEPTH)) full_seen++;
        if (out_front_value !== exp_st.front || out_back_value !== exp_st.back ||
            out_entry_count !== exp_st.count || out_is_empty !== exp_st.empty ||
            out_push_dropped !== exp_st.dropped) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"[%0t] result %0d mismatch: exp front %h back %h count %0d ",
                      "empty %b drop %b, got front %h back %h count %0d empty %b drop %b"},
                     $realtime, checked_count, exp_st.front, exp_st.back, exp_st.count,
                     exp_st.empty, exp_st.dropped, out_front_value, out_back_value,
                     out_entry_count, out_is_empty, out_push_dropped);
        end
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, predicted_status.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus, then drain and verdict
  initial begin : stimulus
    int unsigned idx;
    int unsigned burst_len;
    int unsigned mode;
    int unsigned pct;
    int unsigned roll;
    logic [2:0]  op;
    int unsigned phase_gap[4];
    phase_gap = '{0, 83, 0, 12};

    // directed: empty queue behavior first
    add_request(dq_pkg::OP_NONE, '0, 0);
    add_request(dq_pkg::OP_POP_FRONT, 32'h1234_5678, 0);
    add_request(dq_pkg::OP_POP_BACK, 32'h8765_4321, 0);
    add_request(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 0);
    add_request(dq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 0);
    // unused opcodes behave as a query
    add_request(3'd6, 32'hDEAD_BEEF, 0);
    add_request(3'd7, 32'hFFFF_FFFF, 0);
    add_request(dq_pkg::OP_POP_BACK, '0, 0);
    add_request(dq_pkg::OP_POP_FRONT, '0, 0);
    add_request(dq_pkg::OP_CLEAR, '0, 0);
    // push front from slot 0 wraps, then fill to capacity
    for (int i = 0; i < DEPTH; i++)
      add_request(dq_pkg::OP_PUSH_FRONT,
                  (i % 2) ? 32'hAAAA_5555 ^ i : 32'h5555_AAAA ^ i, 0);
    // pushes into a full queue are refused
    add_request(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 0);
    add_request(dq_pkg::OP_PUSH_FRONT, 32'h0000_0001, 0);
    add_request(dq_pkg::OP_CLEAR, '0, 0);

    // random: bursts that fill, drain or mix, with some noise,
    // split into four idle phases along the run
    idx = 0;
    while (idx < RANDOM_COUNT) begin
      burst_len = $urandom_range(4, 40);
      mode      = $urandom_range(9);
      for (int b = 0; b < burst_len && idx < RANDOM_COUNT; b++) begin
        pct  = phase_gap[(idx * 4) / RANDOM_COUNT];
        roll = $urandom_range(99);
        if (roll < 3) begin
          op = dq_pkg::OP_CLEAR;
        end else if (mode >= 8) begin
          // noise: any code, unused ones included
          op = 3'($urandom);
        end else begin
          roll = $urandom_range(99);
          // fill bursts mostly push, drain bursts mostly pop
          if ((mode < 3 && roll < 80) || (mode >= 3 && mode < 5 && roll < 20) ||
              (mode >= 5 && roll < 50))
            op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
          else if ($urandom_range(9) == 0)
            op = dq_pkg::OP_NONE;
          else
            op = $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
        end
        op_seen[op]++;
        add_request(op, pick_word(), pct);
        idx++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to go out and every result to return
    while (pending_requests.size() != 0 || start || predicted_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d refused pushes, %0d full states",
             taken_count, checked_count, dropped_seen, full_seen);
    $display({"random opcode mix: push back %0d, push front %0d, pop front %0d, ",
              "pop back %0d, clear %0d"},
             op_seen[dq_pkg::OP_PUSH_BACK], op_seen[dq_pkg::OP_PUSH_FRONT],
             op_seen[dq_pkg::OP_POP_FRONT], op_seen[dq_pkg::OP_POP_BACK],
             op_seen[dq_pkg::OP_CLEAR]);
    if (mismatch_count == 0 && predicted_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
